// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_W     = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int CNT_FIELD_W = 5;
  localparam int IDX_FIELD_W = 4;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 112;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                      push;
    logic                      pop;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: inserts, shifts toward the tail on push and
// toward the head on pop, and flags a match against the broadcast tail.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                              clk,
  input  spq_pkg::cell_ctrl_t               ctrl,
  input  logic                              occupied,
  input  logic                              left_take,
  input  logic signed [spq_pkg::VALUE_W-1:0] left_data,
  input  logic signed [spq_pkg::VALUE_W-1:0] right_data,
  input  logic signed [spq_pkg::VALUE_W-1:0] tail,
  output logic                              take,
  output logic signed [spq_pkg::VALUE_W-1:0] data,
  output logic                              tail_match
);

  // take is monotone along the row: free slot or entry no larger than value
  assign take       = !occupied || ($signed(data) <= $signed(ctrl.value));
  assign tail_match = occupied && (data == tail);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (take && !left_take) begin
        data <= ctrl.value;
      end else if (take) begin
        data <= left_data;
      end
    end else if (ctrl.pop) begin
      data <= right_data;
    end
  end

endmodule

// File: rtl/sorted_priority_queue.sv
// An accepted item passes the states S_TAIL and S_OUT before its result is
// registered on the master side; S_TAIL and S_OUT hold the status pass over
// the cell row (tail select, then match and priority encode) after each update.
// No new item is taken until the result leaves S_OUT; a stall holds S_OUT.
// Reset clears the count and the handshake; cell contents are left as is.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of signed values kept in descending order in a
// row of cells, with one status result per accepted item, whatever its op code.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]   s_tdata,   // value[31:0]
  input  logic [spq_pkg::OP_W-1:0]        s_tuser,   // op[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // popped_value[31:0], head_value[63:32], tail_value[95:64],
  // entry_count[100:96], is_empty[101], is_full[102], first_min_index[106:103]
  output logic [spq_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [spq_pkg::STATUS_W-1:0]    m_tuser    // status[1:0]
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TAIL = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  localparam int D  = spq_pkg::DEPTH;
  localparam int VW = spq_pkg::VALUE_W;

  state_t                       state;
  logic [spq_pkg::CNT_W-1:0]    count;
  logic [spq_pkg::CNT_W-1:0]    count_m1;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic signed [VW-1:0]         popped;
  logic signed [VW-1:0]         tail;
  logic signed [VW-1:0]         head;
  logic [spq_pkg::IDX_W-1:0]    min_idx;

  logic                         accept;
  logic                         out_free;
  logic                         is_push;
  logic                         is_pop;
  spq_pkg::cell_ctrl_t          ctrl;

  logic signed [VW-1:0] cell_data [D];
  logic [D-1:0]         cell_take;
  logic [D-1:0]         cell_occ;
  logic [D-1:0]         cell_match;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign is_push  = (s_tuser == spq_pkg::OP_PUSH);
  assign is_pop   = (s_tuser == spq_pkg::OP_POP);
  assign count_m1 = count - spq_pkg::CNT_W'(1);

  assign ctrl.push  = accept && is_push && (count != spq_pkg::CNT_W'(D));
  assign ctrl.pop   = accept && is_pop && (count != '0);
  assign ctrl.value = $signed(s_tdata[VW-1:0]);

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic signed [VW-1:0] left_d;
    logic signed [VW-1:0] right_d;
    logic                 left_t;

    assign cell_occ[i] = (spq_pkg::CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_t = 1'b0;
      assign left_d = ctrl.value;
    end else begin : g_mid
      assign left_t = cell_take[i-1];
      assign left_d = cell_data[i-1];
    end

    if (i == D - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_next
      assign right_d = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (cell_occ[i]),
      .left_take  (left_t),
      .left_data  (left_d),
      .right_data (right_d),
      .tail       (tail),
      .take       (cell_take[i]),
      .data       (cell_data[i]),
      .tail_match (cell_match[i])
    );
  end

  // lowest matching cell
  always_comb begin
    min_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        min_idx = spq_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_TAIL;
            if (ctrl.push) begin
              count <= count + spq_pkg::CNT_W'(1);
            end else if (ctrl.pop) begin
              count <= count_m1;
            end
          end
        end
        S_TAIL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped <= ctrl.pop ? cell_data[0] : '0;
      if (is_push && (count == spq_pkg::CNT_W'(D))) begin
        status <= spq_pkg::ST_FULL;
      end else if (is_pop && (count == '0)) begin
        status <= spq_pkg::ST_EMPTY;
      end else begin
        status <= spq_pkg::ST_OK;
      end
    end
    if (state == S_TAIL) begin
      tail <= (count == '0) ? '0 : cell_data[count_m1[spq_pkg::IDX_W-1:0]];
      head <= (count == '0) ? '0 : cell_data[0];
    end
    if ((state == S_OUT) && out_free) begin
      m_tuser               <= status;
      m_tdata[31:0]         <= popped;
      m_tdata[63:32]        <= head;
      m_tdata[95:64]        <= tail;
      m_tdata[100:96]       <= spq_pkg::CNT_FIELD_W'(count);
      m_tdata[101]          <= (count == '0);
      m_tdata[102]          <= (count == spq_pkg::CNT_W'(D));
      m_tdata[106:103]      <= spq_pkg::IDX_FIELD_W'(min_idx);
      m_tdata[111:107]      <= '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(D))
    else $error("queue count beyond depth");

  a_full_push_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && is_push && (count == spq_pkg::CNT_W'(D))) |=>
      (count == spq_pkg::CNT_W'(D)) && (status == spq_pkg::ST_FULL))
    else $error("push to full queue changed the count");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && is_pop && (count == '0)) |=>
      (count == '0) && (status == spq_pkg::ST_EMPTY) && (popped == '0))
    else $error("pop on empty queue not reported");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT) && out_free) |=>
      (m_tdata[100:96] == spq_pkg::CNT_FIELD_W'(count)) && m_tvalid)
    else $error("result count does not match queue count");
`endif

endmodule

// File: tb/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue. A directed table covers
// the empty and full corners, duplicate extremes and every op code, then a
// long random run alternates fill and drain phases. Each accepted item is
// run through a local sorted-array model; every result on the master side is
// compared field by field with the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;

  localparam logic [spq_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1825;

  typedef struct packed {
    logic [spq_pkg::STATUS_W-1:0]       status;
    logic signed [spq_pkg::VALUE_W-1:0] popped;
    logic signed [spq_pkg::VALUE_W-1:0] head;
    logic signed [spq_pkg::VALUE_W-1:0] tail;
    logic [spq_pkg::CNT_FIELD_W-1:0]    count;
    logic                               empty;
    logic                               full;
    logic [spq_pkg::IDX_FIELD_W-1:0]    min_idx;
  } queue_status_t;

  typedef struct packed {
    logic [spq_pkg::OP_W-1:0]           op;
    logic signed [spq_pkg::VALUE_W-1:0] value;
    logic                               typed;
    queue_status_t                      want;
  } stim_row_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [spq_pkg::IN_DATA_W-1:0]  s_tdata;   // value[31:0]
  logic [spq_pkg::OP_W-1:0]       s_tuser;   // op[1:0]
  logic                           m_tvalid;
  logic                           m_tready;
  // popped_value, head_value, tail_value, entry_count, is_empty, is_full,
  // first_min_index
  logic [spq_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [spq_pkg::STATUS_W-1:0]   m_tuser;   // status[1:0]

  logic signed [spq_pkg::VALUE_W-1:0] sorted_vals [spq_pkg::DEPTH];
  int                                 stored_cnt;
  queue_status_t                      pending_status [$];
  stim_row_t                          dir_rows [$];
  int                                 mismatch_cnt;
  int                                 results_seen;
  bit                                 quiet;
  bit                                 filling;
  queue_status_t                      mon_want;
  queue_status_t                      mon_got;

  sorted_priority_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // sorted-array queue: descending, newest of equal values nearest the head
  function automatic queue_status_t apply_queue_op(
      logic [spq_pkg::OP_W-1:0] op, logic signed [spq_pkg::VALUE_W-1:0] val);
    queue_status_t r;
    int pos;
    bit found;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (op == spq_pkg::OP_PUSH) begin
      if (stored_cnt == spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = stored_cnt;
        found = 1'b0;
        for (int i = 0; i < stored_cnt; i++) begin
          if (!found && sorted_vals[i] <= val) begin
            pos = i;
            found = 1'b1;
          end
        end
        for (int i = stored_cnt; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
        sorted_vals[pos] = val;
        stored_cnt++;
      end
    end else if (op == spq_pkg::OP_POP) begin
      if (stored_cnt == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.popped = sorted_vals[0];
        for (int i = 0; i + 1 < stored_cnt; i++) sorted_vals[i] = sorted_vals[i+1];
        stored_cnt--;
      end
    end
    if (stored_cnt > 0) begin
      r.head = sorted_vals[0];
      r.tail = sorted_vals[stored_cnt-1];
      found = 1'b0;
      for (int i = 0; i < stored_cnt; i++) begin
        if (!found && sorted_vals[i] == r.tail) begin
          r.min_idx = i[spq_pkg::IDX_FIELD_W-1:0];
          found = 1'b1;
        end
      end
    end
    r.count = stored_cnt[spq_pkg::CNT_FIELD_W-1:0];
    r.empty = (stored_cnt == 0);
    r.full  = (stored_cnt == spq_pkg::DEPTH);
    return r;
  endfunction

  function automatic queue_status_t status_of(logic [spq_pkg::STATUS_W-1:0] st,
                                              logic signed [spq_pkg::VALUE_W-1:0] popped,
                                              logic signed [spq_pkg::VALUE_W-1:0] head,
                                              logic signed [spq_pkg::VALUE_W-1:0] tail,
                                              int cnt, int min_idx);
    queue_status_t r;
    r.status  = st;
    r.popped  = popped;
    r.head    = head;
    r.tail    = tail;
    r.count   = cnt[spq_pkg::CNT_FIELD_W-1:0];
    r.empty   = (cnt == 0);
    r.full    = (cnt == spq_pkg::DEPTH);
    r.min_idx = min_idx[spq_pkg::IDX_FIELD_W-1:0];
    return r;
  endfunction

  function automatic void add_row(logic [spq_pkg::OP_W-1:0] op,
                                  logic signed [spq_pkg::VALUE_W-1:0] val,
                                  bit typed, queue_status_t want);
    stim_row_t row;
    row.op    = op;
    row.value = val;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_value();
    logic signed [spq_pkg::VALUE_W-1:0] v;
    case ($urandom_range(9))
      3, 4, 5: v = int'($urandom_range(8)) - 4;
      6:       v = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      7:       v = 32'sh7FFFFFFF - int'($urandom_range(3));
      8:       v = 32'sh80000000 + int'($urandom_range(3));
      9:       v = (stored_cnt > 0) ? sorted_vals[$urandom_range(stored_cnt-1)]
                                    : $urandom;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [spq_pkg::OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r >= 95) return OP_SPARE;
    if (r >= 88) return spq_pkg::OP_QUERY;
    if (filling) return (r < 68) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
    return (r < 68) ? spq_pkg::OP_POP : spq_pkg::OP_PUSH;
  endfunction

  task automatic offer_item(input logic [spq_pkg::OP_W-1:0] op,
                            input logic signed [spq_pkg::VALUE_W-1:0] val,
                            input bit typed, input queue_status_t want);
    queue_status_t r;
    while (!quiet && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_queue_op(op, val);
    pending_status.push_back(typed ? want : r);
  endtask

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen == 400) begin
        hold_left = 150;
        hold_done = 1'b1;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 22);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      mon_got.status  = m_tuser;
      mon_got.popped  = m_tdata[31:0];
      mon_got.head    = m_tdata[63:32];
      mon_got.tail    = m_tdata[95:64];
      mon_got.count   = m_tdata[100:96];
      mon_got.empty   = m_tdata[101];
      mon_got.full    = m_tdata[102];
      mon_got.min_idx = m_tdata[106:103];
      if (pending_status.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected item at %0t: status %0d count %0d", $realtime,
                   mon_got.status, mon_got.count);
      end else begin
        mon_want = pending_status.pop_front();
        if (mon_got.status !== mon_want.status || mon_got.popped !== mon_want.popped ||
            mon_got.head !== mon_want.head || mon_got.tail !== mon_want.tail ||
            mon_got.count !== mon_want.count || mon_got.empty !== mon_want.empty ||
            mon_got.full !== mon_want.full || mon_got.min_idx !== mon_want.min_idx) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch at %0t, item %0d", $realtime, results_seen);
            $display("  exp: st %0d pop %0d head %0d tail %0d cnt %0d e %0d f %0d idx %0d",
                     mon_want.status, mon_want.popped, mon_want.head, mon_want.tail,
                     mon_want.count, mon_want.empty, mon_want.full, mon_want.min_idx);
            $display("  got: st %0d pop %0d head %0d tail %0d cnt %0d e %0d f %0d idx %0d",
                     mon_got.status, mon_got.popped, mon_got.head, mon_got.tail,
                     mon_got.count, mon_got.empty, mon_got.full, mon_got.min_idx);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[sorted_priority_queue] ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = spq_pkg::OP_QUERY;
    stored_cnt = 0;
    mismatch_cnt = 0;
    results_seen = 0;
    quiet = 1'b0;
    filling = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty corners and every op code
    add_row(spq_pkg::OP_QUERY, 0, 1, status_of(spq_pkg::ST_OK, 0, 0, 0, 0, 0));
    add_row(spq_pkg::OP_POP, 0, 1, status_of(spq_pkg::ST_EMPTY, 0, 0, 0, 0, 0));
    add_row(OP_SPARE, -1, 1, status_of(spq_pkg::ST_OK, 0, 0, 0, 0, 0));
    add_row(spq_pkg::OP_PUSH, 32'sh7FFFFFFF, 1,
            status_of(spq_pkg::ST_OK, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1, 0));
    add_row(spq_pkg::OP_PUSH, 32'sh80000000, 1,
            status_of(spq_pkg::ST_OK, 0, 32'sh7FFFFFFF, 32'sh80000000, 2, 1));
    add_row(spq_pkg::OP_PUSH, 32'sh80000000, 1,
            status_of(spq_pkg::ST_OK, 0, 32'sh7FFFFFFF, 32'sh80000000, 3, 1));
    // fill up with duplicates and mixed signs
    add_row(spq_pkg::OP_PUSH, 0, 0, '0);
    add_row(spq_pkg::OP_PUSH, -1, 0, '0);
    add_row(spq_pkg::OP_PUSH, 1, 0, '0);
    add_row(spq_pkg::OP_PUSH, 0, 0, '0);
    add_row(spq_pkg::OP_PUSH, 5, 0, '0);
    add_row(spq_pkg::OP_PUSH, 5, 0, '0);
    add_row(spq_pkg::OP_PUSH, -5, 0, '0);
    add_row(spq_pkg::OP_PUSH, 100, 0, '0);
    add_row(spq_pkg::OP_PUSH, -100, 0, '0);
    add_row(spq_pkg::OP_PUSH, 7, 0, '0);
    add_row(spq_pkg::OP_PUSH, 3, 0, '0);
    add_row(spq_pkg::OP_PUSH, 32'sh7FFFFFFF, 0, '0);
    add_row(spq_pkg::OP_PUSH, 2, 0, '0);
    // push to a full queue is rejected
    add_row(spq_pkg::OP_PUSH, 42, 1,
            status_of(spq_pkg::ST_FULL, 0, 32'sh7FFFFFFF, 32'sh80000000, 16, 14));
    add_row(OP_SPARE, 0, 0, '0);
    add_row(spq_pkg::OP_POP, 0, 1,
            status_of(spq_pkg::ST_OK, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                      15, 13));
    add_row(spq_pkg::OP_POP, 0, 0, '0);
    add_row(spq_pkg::OP_PUSH, 32'sh55555555, 0, '0);
    add_row(spq_pkg::OP_PUSH, 32'shAAAAAAAA, 0, '0);

    foreach (dir_rows[i])
      offer_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 700) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0) @(posedge clk);
      end
      quiet = (n >= 1100 && n < 1400);
      if (filling && stored_cnt == spq_pkg::DEPTH && $urandom_range(99) < 30) filling = 1'b0;
      else if (!filling && stored_cnt == 0 && $urandom_range(99) < 30) filling = 1'b1;
      else if ($urandom_range(99) < 3) filling = !filling;
      offer_item(pick_op(), pick_value(), 0, '0);
    end
    s_tvalid <= 1'b0;
    quiet = 1'b0;

    while (pending_status.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("[sorted_priority_queue] OK");
    else
      $display("[sorted_priority_queue] ERROR");
    $finish;
  end

endmodule
